// ----- design/indexed_shift_insert_table_assert.svh -----
// Assertion macros shared by the indexed shift-insert table design.
`ifndef INDEXED_SHIFT_INSERT_TABLE_ASSERT_SVH
`define INDEXED_SHIFT_INSERT_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISIT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/isit_pkg.sv -----
// Types and constants shared by the indexed shift-insert table modules.
package isit_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int ENTRY_W   = 64;
   localparam int POS_W     = 6;
   localparam int CNT_W     = 7;
   localparam int STAT_W    = 2;
   // Compare width wide enough for any cell index the depth range allows.
   localparam int CMP_W     = 11;

   typedef enum logic [2:0] {
      REQ_UPDATE = 3'd0,
      REQ_INSERT = 3'd1,
      REQ_MOVE   = 3'd2,
      REQ_REMOVE = 3'd3,
      REQ_CLEAR  = 3'd4,
      REQ_READ   = 3'd5
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What the cell row does: hold, write, insert, shift down, shift up or remove.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_SHIFT_DOWN,
      CELL_SHIFT_UP,
      CELL_REMOVE
   } cell_op_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type          op;
      logic [POS_W-1:0]     pos;
      logic [POS_W-1:0]     tgt;
      logic [CNT_W-1:0]     count;
      logic [ENTRY_W-1:0]   data;
   } cell_cmd_type;

endpackage

// ----- design/isit_cell.sv -----
// One cell of the table: holds a single entry and picks its next value.
module isit_cell
   import isit_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [ENTRY_W-1:0]  lower_q,
   input  logic [ENTRY_W-1:0]  upper_q,
   output logic [ENTRY_W-1:0]  q
);

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in;
   logic [CMP_W-1:0]   pos_w;
   logic [CMP_W-1:0]   tgt_w;
   logic [CMP_W-1:0]   cnt_w;
   logic               load;
   logic               take_lower;
   logic               take_upper;

   assign pos_w = CMP_W'(cmd.pos);
   assign tgt_w = CMP_W'(cmd.tgt);
   assign cnt_w = CMP_W'(cmd.count);

   // Decide from the broadcast command where this cell takes its data.
   always_comb begin
      load       = 1'b0;
      take_lower = 1'b0;
      take_upper = 1'b0;
      case (cmd.op)
         CELL_WRITE: begin
            load = (IDX == pos_w);
         end
         CELL_INSERT: begin
            load       = (IDX == pos_w);
            take_lower = (IDX > pos_w) && (IDX <= cnt_w);
         end
         CELL_SHIFT_DOWN: begin
            load       = (IDX == tgt_w);
            take_upper = (IDX >= pos_w) && (IDX < tgt_w);
         end
         CELL_SHIFT_UP: begin
            load       = (IDX == tgt_w);
            take_lower = (IDX > tgt_w) && (IDX <= pos_w);
         end
         CELL_REMOVE: begin
            take_upper = (IDX >= pos_w) && ((IDX + CMP_W'(1)) < cnt_w);
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // Next value of the entry.
   always_comb begin
      if (load) begin
         entry_in = cmd.data;
      end else if (take_lower) begin
         entry_in = lower_q;
      end else if (take_upper) begin
         entry_in = upper_q;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ----- design/indexed_shift_insert_table.sv -----
// Indexed shift-insert table: an ordered list of 64-bit entries in a row of cells.
//
// The req_ channel carries one request item: an update, insert, move, remove,
// clear or read, chosen by req_tuser. Every request yields exactly one result
// item on the rsp_ channel with a status, the live count after the request and,
// for a successful read, the entry read.
// The csr_ channel writes the capacity register; a write that lowers the limit
// clamps the live count at once and leaves the entries in place.
// The result of a request accepted at a clock edge shows on the rsp_ channel
// from the cycle after. Throughput is one item per cycle while rsp_tready is high,
// set by the row of cells, which all shift together in the cycle of acceptance,
// and by the select across the cells that fetches an entry for a read or a move.
// Reset clears the live count and the result valid flag and sets the capacity
// to 64. The entries themselves are not cleared, so there is no clearing pass.
// When the receiver stalls, the result stays in the output register and
// req_tready falls until it is taken; in the cycle it is taken a new item may
// enter.
module indexed_shift_insert_table
   import isit_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   // tdata fields from bit 0: position[5:0], move_target[11:6],
   // entry_value[75:12], zero fill[79:76].
   input  logic [79:0]         req_tdata,
   // tuser fields from bit 0: req_type[2:0].
   input  logic [2:0]          req_tuser,
   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tdata fields from bit 0: live_count[6:0], read_value[70:7], zero fill[71].
   output logic [71:0]         rsp_tdata,
   // tuser fields from bit 0: status[1:0].
   output logic [STAT_W-1:0]   rsp_tuser,
   // Capacity register write channel.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_W-1:0]    csr_data
);

   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

   logic                req_accept;
   logic                csr_accept;
   logic [POS_W-1:0]    req_pos;
   logic [POS_W-1:0]    req_tgt;
   logic [ENTRY_W-1:0]  req_value;
   req_kind_type        req_kind;

   logic [CNT_W-1:0]    capacity_ff;
   logic [CNT_W-1:0]    capacity_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    count_next;
   logic [CNT_W-1:0]    limit;
   logic [CNT_W-1:0]    csr_limit;
   logic [CNT_W-1:0]    pos_c;
   logic [CNT_W-1:0]    tgt_c;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [ENTRY_W-1:0]  rsp_read_ff;

   status_type          status_next;
   logic [ENTRY_W-1:0]  read_next;
   logic [ENTRY_W-1:0]  sel_value;
   cell_op_type         op_next;
   cell_cmd_type        cmd;
   logic [ENTRY_W-1:0]  cell_q [TABLE_DEPTH];

   // Unpack the request item.
   assign req_pos   = req_tdata[5:0];
   assign req_tgt   = req_tdata[11:6];
   assign req_value = req_tdata[75:12];
   assign req_kind  = req_kind_type'(req_tuser);
   assign pos_c     = CNT_W'(req_pos);
   assign tgt_c     = CNT_W'(req_tgt);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // Limit in force: the smaller of capacity and depth.
   assign limit     = (CMP_W'(capacity_ff) < DEPTH_C) ? capacity_ff : DEPTH_C[CNT_W-1:0];
   assign csr_limit = (CMP_W'(csr_data) < DEPTH_C) ? csr_data : DEPTH_C[CNT_W-1:0];

   // Entry at the request position, used by read and as the entry a move lifts.
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (CMP_W'(i) == CMP_W'(req_pos)) begin
            sel_value = sel_value | cell_q[i];
         end
      end
   end

   // Check the request and work out status, count and the row command.
   always_comb begin
      status_next = ST_OK;
      count_next  = count_ff;
      read_next   = '0;
      op_next     = CELL_HOLD;
      case (req_kind)
         REQ_UPDATE: begin
            if (pos_c >= limit) begin
               status_next = ST_RANGE;
            end else begin
               op_next = CELL_WRITE;
               if (pos_c + CNT_W'(1) > count_ff) begin
                  count_next = pos_c + CNT_W'(1);
               end
            end
         end
         REQ_INSERT: begin
            if (pos_c >= limit) begin
               status_next = ST_RANGE;
            end else if (count_ff >= limit) begin
               status_next = ST_FULL;
            end else begin
               op_next    = CELL_INSERT;
               count_next = count_ff + CNT_W'(1);
            end
         end
         REQ_MOVE: begin
            if (pos_c >= count_ff || tgt_c >= count_ff) begin
               status_next = ST_RANGE;
            end else if (pos_c < tgt_c) begin
               op_next = CELL_SHIFT_DOWN;
            end else if (pos_c > tgt_c) begin
               op_next = CELL_SHIFT_UP;
            end
         end
         REQ_REMOVE: begin
            if (pos_c >= count_ff) begin
               status_next = ST_RANGE;
            end else begin
               op_next    = CELL_REMOVE;
               count_next = count_ff - CNT_W'(1);
            end
         end
         REQ_CLEAR: begin
            count_next = '0;
         end
         REQ_READ: begin
            if (pos_c >= count_ff) begin
               status_next = ST_RANGE;
            end else begin
               read_next = sel_value;
            end
         end
         default: begin
            status_next = ST_OK;
         end
      endcase
   end

   // Command to the cell row; the row holds unless an item is taken.
   always_comb begin
      cmd.op    = req_accept ? op_next : CELL_HOLD;
      cmd.pos   = req_pos;
      cmd.tgt   = req_tgt;
      cmd.count = count_ff;
      cmd.data  = (req_kind == REQ_MOVE) ? sel_value : req_value;
   end

   // Row of cells, each wired to its two neighbours.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [ENTRY_W-1:0] lower_q;
      logic [ENTRY_W-1:0] upper_q;
      if (g == 0) begin : g_first
         assign lower_q = '0;
      end else begin : g_inner_lo
         assign lower_q = cell_q[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_last
         assign upper_q = '0;
      end else begin : g_inner_hi
         assign upper_q = cell_q[g+1];
      end
      isit_cell #(
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .lower_q (lower_q),
         .upper_q (upper_q),
         .q       (cell_q[g])
      );
   end

   // Capacity and live count.
   always_comb begin
      capacity_in = capacity_ff;
      count_in    = count_ff;
      if (csr_accept) begin
         capacity_in = csr_data;
         if (count_ff > csr_limit) begin
            count_in = csr_limit;
         end
      end else if (req_accept) begin
         count_in = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CNT_W'(64);
         count_ff    <= '0;
      end else begin
         capacity_ff <= capacity_in;
         count_ff    <= count_in;
      end
   end

   // Output register for the result item.
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff <= status_next;
         rsp_count_ff  <= count_next;
         rsp_read_ff   <= read_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_read_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Checks on the table's own logic.
`include "indexed_shift_insert_table_assert.svh"

   `ISIT_ASSERT_SAME(a_count_in_limit, clock, reset, 1'b1, count_ff <= limit,
                     "count above limit")
   `ISIT_ASSERT_NEXT(a_clear_zeroes, clock, reset, req_accept && req_kind == REQ_CLEAR,
                     rsp_count_ff == '0, "clear left a count")
   `ISIT_ASSERT_NEXT(a_fail_keeps_count, clock, reset,
                     req_accept && !csr_accept && status_next != ST_OK,
                     count_ff == $past(count_ff), "failed request changed count")
   `ISIT_ASSERT_SAME(a_fail_reads_zero, clock, reset,
                     rsp_valid_ff && rsp_status_ff != ST_OK, rsp_read_ff == '0,
                     "failed request returned data")

endmodule
